FILE: sv/arsg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// arsg_pkg
// Shared types, codes and helpers for the arithmetic range sequence generator.
// ============================================================================
package arsg_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int DIV_W  = 37;
    localparam int TAG_W  = 16;

    // request kinds carried on s_axis_tuser
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_NEXT = 2'd1;
    localparam logic [1:0] REQ_SKIP = 2'd2;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_WIDTH_CODE = 2'd0;
    localparam logic [1:0] REG_SIGNED     = 2'd1;
    localparam logic [1:0] REG_DIVISOR    = 2'd2;

    // element width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_STEP,
        ST_CHECK,
        ST_DIV_COUNT,
        ST_FINISH
    } state_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
        logic [DATA_W-1:0] m;
        unique case (code)
            WIDTH_8:  m = DATA_W'(64'hFF);
            WIDTH_16: m = DATA_W'(64'hFFFF);
            WIDTH_32: m = DATA_W'(64'hFFFF_FFFF);
            default:  m = '1;
        endcase
        return m;
    endfunction

    // map a bit pattern to its position in unsigned order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v,
                                                    input logic [1:0]        code,
                                                    input logic              sgn);
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] k;
        m = width_mask(code);
        k = v & m;
        if (sgn)
            k = k ^ ((m >> 1) + DATA_W'(1));
        return k;
    endfunction

endpackage

FILE: sv/arithmetic_range_sequence_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// arithmetic_range_sequence_generator
// Integer range iterator: load a range, then step through its elements.
// ============================================================================
// Usage:
//   Requests arrive on the s_axis channel, one transfer per request; the kind
//   (load, next, skip) is on s_axis_tuser. Every request gives exactly one
//   result transfer on m_axis. Element width, signedness and the step divisor
//   are set through the APB port while no request is in flight.
//   Next and skip requests are handled in the cycle they are accepted; the
//   result is registered and shows on m_axis in the next cycle, so they run
//   one per cycle while the receiver keeps m_axis_tready high.
//   A load runs up to two 64-bit divisions on one shared bit-serial divider
//   (step by divisor, then range length by step); the second division is
//   skipped when the range is found empty after the first division.
//   s_axis_tready is low meanwhile.
//   Results sit in an output register. A new request is taken only while
//   that register is empty or being drained, so a stalled receiver holds
//   back the input side without losing or repeating any result.
//   Reset empties the output register, clears the range state (count zero,
//   so next/skip report exhausted) and restores width 64, signed, divisor 1.
// ============================================================================
module arithmetic_range_sequence_generator (
    input  logic          clk,
    input  logic          rst_n,
    // APB configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [207:0]  s_axis_tdata,  // range_start, range_end, step_raw, zone_tag
    input  logic [1:0]    s_axis_tuser,  // req_type
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,  // element_value, remaining, zone_out
    output logic [0:0]    m_axis_tuser   // ok
);
    import arsg_pkg::*;

    // configuration registers
    logic [1:0]       width_code_reg;
    logic             elem_signed_reg;
    logic [DIV_W-1:0] divisor_reg;

    // range state
    logic [DATA_W-1:0] cur_reg;
    logic [DATA_W-1:0] step_reg;
    logic [DATA_W-1:0] count_reg;
    logic [TAG_W-1:0]  zone_reg;

    // load working registers
    logic              neg_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] mag_reg;

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_rem_reg;
    logic [TAG_W-1:0]  out_zone_reg;

    state_t state_reg, state_next;

    // unpacked request
    logic [1:0]        req_type;
    logic [DATA_W-1:0] range_start;
    logic [DATA_W-1:0] range_end;
    logic [DATA_W-1:0] step_raw;
    logic [TAG_W-1:0]  zone_tag;

    logic              in_xfer;
    logic              cfg_wr;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] raw_mag;
    logic [DATA_W-1:0] eff_divisor;
    logic [DATA_W-1:0] key_start;
    logic [DATA_W-1:0] key_end;
    logic [DATA_W-1:0] step_mag;
    logic              range_empty;

    // divider hookup
    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_rem;

    assign req_type    = s_axis_tuser;
    assign range_start = s_axis_tdata[63:0];
    assign range_end   = s_axis_tdata[127:64];
    assign step_raw    = s_axis_tdata[191:128];
    assign zone_tag    = s_axis_tdata[207:192];

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    assign mask        = width_mask(width_code_reg);
    assign raw_mag     = step_raw[DATA_W-1] ? (DATA_W'(0) - step_raw) : step_raw;
    assign eff_divisor = (divisor_reg == '0) ? DATA_W'(1) : DATA_W'(divisor_reg);
    assign key_start   = order_key(range_start, width_code_reg, elem_signed_reg);
    assign key_end     = order_key(range_end, width_code_reg, elem_signed_reg);

    // exact division keeps the quotient, any remainder kills the step
    assign step_mag    = (div_rem != '0) ? '0 : div_quo;
    assign range_empty = (mag_reg == '0) || (lo_reg >= hi_reg);

    // ------------------------------------------------------------------
    // configuration read-back
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (paddr[4:3])
            REG_WIDTH_CODE: prdata = DATA_W'(width_code_reg);
            REG_SIGNED:     prdata = DATA_W'(elem_signed_reg);
            REG_DIVISOR:    prdata = DATA_W'(divisor_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg  <= WIDTH_64;
            elem_signed_reg <= 1'b1;
            divisor_reg     <= DIV_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_WIDTH_CODE: width_code_reg  <= pwdata[1:0];
                REG_SIGNED:     elem_signed_reg <= pwdata[0];
                REG_DIVISOR:    divisor_reg     <= pwdata[DIV_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer && req_type == REQ_LOAD)
                    state_next = ST_DIV_STEP;
            ST_DIV_STEP:
                if (div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = range_empty ? ST_FINISH : ST_DIV_COUNT;
            ST_DIV_COUNT:
                if (div_done)
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_dividend  = raw_mag;
        div_divisor   = eff_divisor;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = !out_valid_reg || m_axis_tready;
                div_start     = in_xfer && (req_type == REQ_LOAD);
            end
            ST_CHECK:
            begin
                div_start    = !range_empty;
                div_dividend = hi_reg - lo_reg;
                div_divisor  = mag_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // range state and load working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            step_reg  <= '0;
            count_reg <= '0;
            zone_reg  <= '0;
            neg_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mag_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                if (req_type == REQ_LOAD)
                begin
                    neg_reg  <= step_raw[DATA_W-1];
                    // negative step walks downward: swap the bounds
                    lo_reg   <= step_raw[DATA_W-1] ? key_end : key_start;
                    hi_reg   <= step_raw[DATA_W-1] ? key_start : key_end;
                    cur_reg  <= range_start & mask;
                    zone_reg <= zone_tag;
                end
                else if ((req_type == REQ_NEXT || req_type == REQ_SKIP)
                         && count_reg != '0)
                begin
                    cur_reg   <= (cur_reg + step_reg) & mask;
                    count_reg <= count_reg - DATA_W'(1);
                end
            end

            if (state_reg == ST_DIV_STEP && div_done)
            begin
                mag_reg  <= step_mag;
                step_reg <= neg_reg ? (DATA_W'(0) - step_mag) : step_mag;
            end

            if (state_reg == ST_CHECK && range_empty)
                count_reg <= '0;

            // ceiling of length over step
            if (state_reg == ST_DIV_COUNT && div_done)
                count_reg <= div_quo + DATA_W'(div_rem != '0);
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((in_xfer && req_type != REQ_LOAD) || state_reg == ST_FINISH)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            out_value_reg <= '0;
            out_ok_reg    <= (count_reg != '0);
            out_rem_reg   <= count_reg;
            out_zone_reg  <= '0;
        end
        else if (in_xfer && req_type != REQ_LOAD)
        begin
            out_value_reg <= '0;
            out_ok_reg    <= 1'b0;
            out_rem_reg   <= '0;
            out_zone_reg  <= '0;
            unique case (req_type)
                REQ_NEXT, REQ_SKIP:
                    if (count_reg != '0)
                    begin
                        out_ok_reg  <= 1'b1;
                        out_rem_reg <= count_reg - DATA_W'(1);
                        if (req_type == REQ_NEXT)
                        begin
                            out_value_reg <= cur_reg & mask;
                            out_zone_reg  <= zone_reg;
                        end
                    end
                default:
                    // unknown request reports the count untouched
                    out_rem_reg <= count_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_zone_reg, out_rem_reg, out_value_reg};
    assign m_axis_tuser  = out_ok_reg;

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    arsg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

endmodule

FILE: sv/arsg_div.sv
`timescale 1ns / 1ps
// ============================================================================
// arsg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ============================================================================
module arsg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [arsg_pkg::DATA_W-1:0] dividend,
    input  logic [arsg_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [arsg_pkg::DATA_W-1:0] quotient,
    output logic [arsg_pkg::DATA_W-1:0] remainder
);
    import arsg_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (!trial[DATA_W])
        begin
            rem_next = trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_reg + CNT_W'(1);
            busy_reg <= (cnt_reg != LAST_STEP);
            done_reg <= (cnt_reg == LAST_STEP);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
